### rtl/eip_pkg.sv
// Package: shared types and constants for the expression input prefilter.
`default_nettype none

package eip_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_LOW       = 8'd32;
    localparam logic [BYTE_W-1:0] CH_HIGH      = 8'd126;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_HASH      = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'h24;
    localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_QUESTION  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_AT        = 8'h40;
    localparam logic [BYTE_W-1:0] CH_LSQUARE   = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_RSQUARE   = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_BACKTICK  = 8'h60;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_CHAR   = 3'd1,
        ST_PAREN  = 3'd2,
        ST_SQUARE = 3'd3,
        ST_END    = 3'd4,
        ST_LONG   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        CL_PLAIN,
        CL_SPACE,
        CL_DQUOTE,
        CL_BACKSLASH,
        CL_FORBID,
        CL_INVALID,
        CL_LPAREN,
        CL_RPAREN,
        CL_LSQUARE,
        CL_RSQUARE
    } t_class;

    typedef struct packed {
        t_class              cls;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } t_item;

    // Queue head handshake toward the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

`default_nettype wire

### rtl/eip_front.sv
// Front end: classifies each incoming byte into a character class.
`default_nettype none

module eip_front
    import eip_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_last_byte,
    output t_item                  o_item
);

    t_class w_cls;

    always_comb begin
        if (i_in_byte < CH_LOW || i_in_byte > CH_HIGH) begin
            w_cls = CL_INVALID;
        end else begin
            unique case (i_in_byte)
                CH_SPACE:     w_cls = CL_SPACE;
                CH_DQUOTE:    w_cls = CL_DQUOTE;
                CH_BACKSLASH: w_cls = CL_BACKSLASH;
                CH_LPAREN:    w_cls = CL_LPAREN;
                CH_RPAREN:    w_cls = CL_RPAREN;
                CH_LSQUARE:   w_cls = CL_LSQUARE;
                CH_RSQUARE:   w_cls = CL_RSQUARE;
                CH_HASH, CH_DOLLAR, CH_SQUOTE, CH_COLON, CH_QUESTION,
                CH_AT, CH_BACKTICK, CH_LBRACE, CH_RBRACE:
                              w_cls = CL_FORBID;
                default:      w_cls = CL_PLAIN;
            endcase
        end
    end

    assign o_item.cls  = w_cls;
    assign o_item.data = i_in_byte;
    assign o_item.last = i_last_byte;

endmodule

`default_nettype wire

### rtl/eip_queue.sv
// Short word queue between the classifier and the string checker.
`default_nettype none

module eip_queue
    import eip_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_head      o_head
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    logic w_push;
    logic w_pop;

    assign o_full = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_push && !w_pop)      r_count <= r_count + 1'b1;
            else if (!w_push && w_pop) r_count <= r_count - 1'b1;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

### rtl/eip_back.sv
// Back end: string state, error latch, counters and the output register.
`default_nettype none

module eip_back
    import eip_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    input  wire t_head             i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_keep,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic [2:0]             o_status,
    output logic                   o_string_done,
    output logic [LEN_W-1:0]       o_kept_length
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [LEN_W-1:0]        r_max_len;
    logic [COUNT_WIDTH-1:0]  r_round, n_round;
    logic [COUNT_WIDTH-1:0]  r_square, n_square;
    logic                    r_quote, n_quote;
    logic                    r_esc, n_esc;
    logic [COUNT_WIDTH-1:0]  r_seen, n_seen;
    logic [COUNT_WIDTH-1:0]  r_kept, n_kept;
    t_status                 r_err, n_err;

    logic                    r_out_valid;
    logic                    r_keep, n_keep;
    logic [BYTE_W-1:0]       r_byte, n_byte;
    logic [2:0]              r_status;
    logic                    r_done;
    logic [LEN_W-1:0]        r_klen, n_klen;

    t_status                 w_err;
    logic [CMP_W-1:0]        w_kept_ext;
    t_item                   w_it;

    assign w_it  = i_head.item;
    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_round  = r_round;
        n_square = r_square;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_seen   = r_seen;
        n_kept   = r_kept;
        n_err    = r_err;
        n_keep   = 1'b0;
        w_err    = ST_OK;

        if (r_err == ST_OK) begin
            priority if (CMP_W'(r_seen) >= CMP_W'(r_max_len)) begin
                w_err = ST_LONG;
            end else if (w_it.cls == CL_INVALID) begin
                w_err = ST_CHAR;
            end else if (!r_quote &&
                         (w_it.cls == CL_FORBID || w_it.cls == CL_BACKSLASH)) begin
                w_err = ST_CHAR;
            end else if (r_quote) begin
                n_keep = 1'b1;
                priority if (r_esc)                  n_esc   = 1'b0;
                else if (w_it.cls == CL_DQUOTE)      n_quote = 1'b0;
                else if (w_it.cls == CL_BACKSLASH)   n_esc   = 1'b1;
                else                                 n_esc   = r_esc;
            end else begin
                n_keep = (w_it.cls != CL_SPACE);
                unique case (w_it.cls)
                    CL_DQUOTE:  n_quote = 1'b1;
                    CL_LPAREN:  n_round = (r_round == CNT_MAX) ? r_round : r_round + 1'b1;
                    CL_RPAREN: begin
                        if (r_round != '0) n_round = r_round - 1'b1;
                        else               w_err   = ST_PAREN;
                    end
                    CL_LSQUARE: n_square = (r_square == CNT_MAX) ? r_square
                                                                 : r_square + 1'b1;
                    CL_RSQUARE: begin
                        if (r_square != '0) n_square = r_square - 1'b1;
                        else                w_err    = ST_SQUARE;
                    end
                    default: ;
                endcase
            end

            if (w_err != ST_OK) begin
                n_keep = 1'b0;
                n_err  = w_err;
            end else begin
                n_seen = (r_seen == CNT_MAX) ? r_seen : r_seen + 1'b1;
                if (n_keep) n_kept = (r_kept == CNT_MAX) ? r_kept : r_kept + 1'b1;
                if (w_it.last && (n_round != '0 || n_square != '0 || n_quote))
                    n_err = ST_END;
            end
        end

        n_byte     = n_keep ? w_it.data : '0;
        w_kept_ext = CMP_W'(n_kept);
        n_klen     = (w_kept_ext > CMP_W'(MAX_LEN_RESET)) ? MAX_LEN_RESET
                                                          : w_kept_ext[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_round     <= '0;
            r_square    <= '0;
            r_quote     <= 1'b0;
            r_esc       <= 1'b0;
            r_seen      <= '0;
            r_kept      <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_len <= i_cfg_data;
            if (o_pop) begin
                r_out_valid <= 1'b1;
                if (w_it.last) begin
                    r_round  <= '0;
                    r_square <= '0;
                    r_quote  <= 1'b0;
                    r_esc    <= 1'b0;
                    r_seen   <= '0;
                    r_kept   <= '0;
                    r_err    <= ST_OK;
                end else begin
                    r_round  <= n_round;
                    r_square <= n_square;
                    r_quote  <= n_quote;
                    r_esc    <= n_esc;
                    r_seen   <= n_seen;
                    r_kept   <= n_kept;
                    r_err    <= n_err;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each popped word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_keep   <= n_keep;
            r_byte   <= n_byte;
            r_status <= n_err;
            r_done   <= w_it.last;
            r_klen   <= n_klen;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_keep        = r_keep;
    assign o_out_byte    = r_byte;
    assign o_status      = r_status;
    assign o_string_done = r_done;
    assign o_kept_length = r_klen;

endmodule

`default_nettype wire

### rtl/expression_input_prefilter_top.sv
// Top level of the expression input prefilter: classifier, queue and checker.
// An accepted word is written into the queue, then popped into the output register.
// Throughput: one word per cycle while the output is not stalled.
// A four-word queue lets the input side keep taking words while the output stalls.
// Reset (synchronous, active low) empties the queue, clears all string state
// and the output valid flag, and sets max_length to 65535.
`default_nettype none

module expression_input_prefilter_top
    import eip_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    // input word channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_last_byte,
    // result word channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_keep,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic [2:0]             o_status,
    output logic                   o_string_done,
    output logic [LEN_W-1:0]       o_kept_length
);

    t_item w_item;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    // Front: byte classification, pushed straight into the queue
    eip_front u_front (
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .o_item      (w_item)
    );

    assign o_in_stall = w_full;

    eip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Back: per-string state machine and registered result
    eip_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_keep        (o_keep),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_string_done (o_string_done),
        .o_kept_length (o_kept_length)
    );

    // An accepted word is waiting in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_head.valid)
        else $error("accepted word missing from queue");

    // A kept byte never carries a character, bracket or length error
    a_keep_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_keep) |-> (o_status == ST_OK || o_status == ST_END))
        else $error("kept byte with error status");

    // Dropped bytes are zeroed on the output
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_keep) |-> (o_out_byte == '0))
        else $error("dropped byte not zeroed");

    // Checker only pops when the queue holds a word
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
